// ===== rtl/core/wsbms_pkg.sv =====
// Shared types and constants of the wait-state byte memory slave.
// Used by the channel interfaces, the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package wsbms_pkg;

   // Field widths of the bus transfer
   localparam int ADDR_WIDTH      = 32;
   localparam int DATA_WIDTH      = 32;
   localparam int SIZE_WIDTH      = 2;
   localparam int WAIT_WIDTH      = 8;
   localparam int CNT_WIDTH       = 9;
   localparam int BYTE_IDX_WIDTH  = 2;
   localparam int CSR_INDEX_WIDTH = 1;

   // Operation codes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Size codes
   localparam logic [SIZE_WIDTH-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_WIDTH-1:0] SIZE_HALF = 2'd1;
   localparam logic [SIZE_WIDTH-1:0] SIZE_WORD = 2'd2;

   // Response status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_WAIT = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE_ADDRESS = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WAIT_STATES  = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_write;
      logic accept;
      logic offset_step;
      logic load_ptr;
      logic access_step;
      logic finish;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic access_ok;
      logic offset_done;
      logic last_byte;
      logic rsp_free;
   } ctrl_status_type;

endpackage

// ===== rtl/core/wsbms_if.sv =====
// Request and response channel interfaces of the byte memory slave.
// Depends on wsbms_pkg for the field widths.
`timescale 1ns / 1ps

interface wsbms_req_if import wsbms_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [ADDR_WIDTH-1:0] address;
   logic [SIZE_WIDTH-1:0] size_code;
   logic [DATA_WIDTH-1:0] write_data;

   modport source (output valid, operation, address, size_code, write_data, input ready);
   modport sink   (input valid, operation, address, size_code, write_data, output ready);
endinterface

interface wsbms_rsp_if import wsbms_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  status;
   logic [DATA_WIDTH-1:0] read_data;

   modport source (output valid, status, read_data, input ready);
   modport sink   (input valid, status, read_data, output ready);
endinterface

// ===== rtl/core/wsbms_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wsbms_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 4096,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/wsbms_ctrl.sv =====
// Controller state machine of the byte memory slave.
// Depends on wsbms_pkg for the command and status structs.
`timescale 1ns / 1ps

module wsbms_ctrl import wsbms_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_OFFSET = 5'b00100,
      ST_ACCESS = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Decode state into commands and next state
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = status.rsp_free;
            if (req_valid && status.rsp_free) begin
               cmd.accept = 1'b1;
               if (status.access_ok) begin
                  state_in = ST_OFFSET;
               end
            end
         end
         ST_OFFSET: begin
            cmd.offset_step = !status.offset_done;
            if (status.offset_done) begin
               cmd.load_ptr = 1'b1;
               state_in     = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            cmd.access_step = 1'b1;
            if (status.last_byte) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // The finish step always follows the last byte of an access
   a_finish_after_access: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> $past(state_ff) == ST_ACCESS)
      else $error("finish step entered without a preceding access");
`endif

endmodule

// ===== rtl/core/wsbms_datapath.sv =====
// Datapath of the byte memory slave: registers, wait counter, offset unit,
// byte pointer, byte store and response register.
// Depends on wsbms_pkg and wsbms_ram.
`timescale 1ns / 1ps

module wsbms_datapath import wsbms_pkg::*; #(
   parameter int MEM_BYTES = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctrl_cmd_type               cmd,
   output ctrl_status_type            status,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_wr_data,
   input  logic                       req_operation,
   input  logic [ADDR_WIDTH-1:0]      req_address,
   input  logic [SIZE_WIDTH-1:0]      req_size_code,
   input  logic [DATA_WIDTH-1:0]      req_write_data,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic                       rsp_status,
   output logic [DATA_WIDTH-1:0]      rsp_read_data
);

   localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
   localparam logic [AW-1:0] LAST_OFFSET = AW'(MEM_BYTES - 1);
   localparam bit POW2 = (MEM_BYTES & (MEM_BYTES - 1)) == 0;
   localparam logic signed [CNT_WIDTH-1:0] CNT_NEG_ONE = '1;

   // Configuration registers
   logic [ADDR_WIDTH-1:0] base_ff;
   logic [WAIT_WIDTH-1:0] ws_ff;

   // Wait counter
   logic signed [CNT_WIDTH-1:0] cnt_ff;
   logic signed [CNT_WIDTH-1:0] cnt_in;
   logic signed [CNT_WIDTH-1:0] cnt_dec;
   logic                        access_ok;

   // Captured request
   logic                      op_ff;
   logic [DATA_WIDTH-1:0]     wdata_ff;
   logic [BYTE_IDX_WIDTH-1:0] nlast_ff;
   logic [BYTE_IDX_WIDTH-1:0] nlast_in;
   logic [ADDR_WIDTH-1:0]     diff;

   // Byte walk and read assembly
   logic [AW-1:0]             ptr_ff;
   logic [AW-1:0]             ptr_next;
   logic [AW-1:0]             offset;
   logic                      offset_done;
   logic [BYTE_IDX_WIDTH-1:0] byte_idx_ff;
   logic                      rd_pend_ff;
   logic [BYTE_IDX_WIDTH-1:0] rd_idx_ff;
   logic [DATA_WIDTH-1:0]     rdata_ff;
   logic [DATA_WIDTH-1:0]     rdata_merge;
   logic                      ram_wr_en;
   logic [7:0]                ram_wr_data;
   logic [7:0]                ram_rd_data;

   // Response register
   logic                  rsp_valid_ff;
   logic                  rsp_status_ff;
   logic [DATA_WIDTH-1:0] rsp_data_ff;
   logic                  load_wait;
   logic                  load_done;
   logic                  rsp_free;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         ws_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_ff <= csr_wr_data;
            CSR_WAIT_STATES:  ws_ff   <= csr_wr_data[WAIT_WIDTH-1:0];
         endcase
      end
   end

   // Lower the counter, saturating at minus one, and decide OK or WAIT
   always_comb begin
      if (cnt_ff == CNT_NEG_ONE) begin
         cnt_dec = CNT_NEG_ONE;
      end else begin
         cnt_dec = cnt_ff - CNT_WIDTH'(1);
      end
      access_ok = (ws_ff == '0) || (cnt_dec == '0);
      if (access_ok) begin
         cnt_in = cnt_dec;
      end else if (cnt_dec[CNT_WIDTH-1]) begin
         cnt_in = {1'b0, ws_ff};
      end else begin
         cnt_in = cnt_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.accept) begin
         cnt_ff <= cnt_in;
      end
   end

   // Decode size into index of the last byte
   always_comb begin
      unique case (req_size_code)
         SIZE_BYTE: nlast_in = 2'd0;
         SIZE_HALF: nlast_in = 2'd1;
         SIZE_WORD: nlast_in = 2'd3;
         default:   nlast_in = 2'd3;
      endcase
   end

   assign diff = req_address - base_ff;

   // Hold the request for the byte walk
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_operation;
         wdata_ff <= req_write_data;
         nlast_ff <= nlast_in;
      end
   end

   // Reduce the offset modulo the memory size
   if (POW2) begin : g_mask
      logic [AW-1:0] off_ff;

      always_ff @(posedge clock) begin
         if (cmd.accept) begin
            off_ff <= diff[AW-1:0];
         end
      end

      assign offset      = off_ff;
      assign offset_done = 1'b1;
   end else begin : g_rem
      // Floor of 2^32 over the store size; the quotient estimate is low by at most one
      localparam logic [ADDR_WIDTH-1:0] RECIP =
         ADDR_WIDTH'((64'd1 << ADDR_WIDTH) / 64'(MEM_BYTES));
      localparam logic [ADDR_WIDTH-1:0] MEM_SIZE   = ADDR_WIDTH'(MEM_BYTES);
      localparam logic [AW:0]           MEM_SIZE_W = (AW + 1)'(MEM_BYTES);
      localparam logic [1:0]            STEP_QUOT  = 2'd0;
      localparam logic [1:0]            STEP_REM   = 2'd1;
      localparam logic [1:0]            STEP_FIX   = 2'd2;
      localparam logic [1:0]            STEP_DONE  = 2'd3;

      logic [ADDR_WIDTH-1:0]   diff_ff;
      logic [ADDR_WIDTH-1:0]   quot_ff;
      logic [AW:0]             low_ff;
      logic [AW-1:0]           rem_ff;
      logic [1:0]              step_ff;
      logic [2*ADDR_WIDTH-1:0] prod;
      logic [ADDR_WIDTH-1:0]   rem_full;
      logic [AW:0]             low_sub;

      // Quotient by reciprocal multiply, remainder below twice the size, one correction
      assign prod     = {{ADDR_WIDTH{1'b0}}, diff_ff} * {{ADDR_WIDTH{1'b0}}, RECIP};
      assign rem_full = diff_ff - quot_ff * MEM_SIZE;
      assign low_sub  = low_ff - MEM_SIZE_W;

      always_ff @(posedge clock) begin
         if (reset) begin
            step_ff <= STEP_QUOT;
         end else if (cmd.accept) begin
            step_ff <= STEP_QUOT;
         end else if (cmd.offset_step) begin
            step_ff <= step_ff + 2'd1;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.accept) begin
            diff_ff <= diff;
         end
         if (cmd.offset_step && (step_ff == STEP_QUOT)) begin
            quot_ff <= prod[2*ADDR_WIDTH-1:ADDR_WIDTH];
         end
         if (cmd.offset_step && (step_ff == STEP_REM)) begin
            low_ff <= rem_full[AW:0];
         end
         if (cmd.offset_step && (step_ff == STEP_FIX)) begin
            rem_ff <= (low_ff >= MEM_SIZE_W) ? low_sub[AW-1:0] : low_ff[AW-1:0];
         end
      end

      assign offset      = rem_ff;
      assign offset_done = step_ff == STEP_DONE;
   end

   // Advance the byte pointer with wrap at the top of the store
   assign ptr_next = (ptr_ff == LAST_OFFSET) ? '0 : ptr_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (cmd.load_ptr) begin
         ptr_ff <= offset;
      end else if (cmd.clear_write || cmd.access_step) begin
         ptr_ff <= ptr_next;
      end
   end

   // Count bytes of the access and track the pending read byte
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_idx_ff <= '0;
         rd_pend_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            byte_idx_ff <= '0;
         end else if (cmd.access_step) begin
            byte_idx_ff <= byte_idx_ff + BYTE_IDX_WIDTH'(1);
         end
         rd_pend_ff <= cmd.access_step && (op_ff == OP_READ);
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= byte_idx_ff;
   end

   // Byte store
   assign ram_wr_en   = cmd.clear_write || (cmd.access_step && (op_ff == OP_WRITE));
   assign ram_wr_data = cmd.clear_write ? 8'h00 : wdata_ff[{byte_idx_ff, 3'b000} +: 8];

   wsbms_ram #(
      .WIDTH (8),
      .DEPTH (MEM_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .addr    (ptr_ff),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   // Merge the returning read byte into the assembled word
   always_comb begin
      rdata_merge = rdata_ff;
      if (rd_pend_ff) begin
         rdata_merge[{rd_idx_ff, 3'b000} +: 8] = ram_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rdata_ff <= '0;
      end else begin
         rdata_ff <= rdata_merge;
      end
   end

   // Response register: load a WAIT at an accept that is not OK, or an OK at finish
   assign load_wait = cmd.accept && !access_ok;
   assign load_done = cmd.finish;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_wait || load_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_wait) begin
         rsp_status_ff <= STATUS_WAIT;
         rsp_data_ff   <= '0;
      end else if (load_done) begin
         rsp_status_ff <= STATUS_OK;
         rsp_data_ff   <= (op_ff == OP_WRITE) ? '0 : rdata_merge;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_data_ff;

   // Status to the controller
   assign status.clear_last  = ptr_ff == LAST_OFFSET;
   assign status.access_ok   = access_ok;
   assign status.offset_done = offset_done;
   assign status.last_byte   = byte_idx_ff == nlast_ff;
   assign status.rsp_free    = rsp_free;

`ifndef SYNTHESIS
   // Counter never leaves minus one to the largest wait count
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      !(cnt_ff[CNT_WIDTH-1] && (cnt_ff != CNT_NEG_ONE)))
      else $error("wait counter below minus one");

   // Byte pointer stays inside the store
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= LAST_OFFSET)
      else $error("byte pointer past the top of the store");

   // A response is never loaded over one that is still waiting
   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      (load_wait || load_done) |-> rsp_free)
      else $error("response register overwritten");
`endif

endmodule

// ===== rtl/core/wait_state_byte_memory_slave_core.sv =====
// Top level of the wait-state byte memory slave.
// Depends on wsbms_pkg, wsbms_if, wsbms_ctrl and wsbms_datapath.
`timescale 1ns / 1ps

// Byte-addressed memory slave with programmable wait states. Each request
// transfer is one access attempt; each produces exactly one response transfer.
// After reset the store is cleared one byte per cycle, and no request is
// taken during that pass (register writes are). An attempt that answers WAIT
// loads its response at the accept. An attempt that completes goes through an
// accept step, offset reduction (by a reciprocal multiply and one correction
// when MEM_BYTES is not a power of two), a walk of its bytes (1, 2 or 4)
// through the single byte-wide memory port, and a finish step that loads
// the response. The response sits in an output register; a new request is
// taken while the previous response is consumed.

module wait_state_byte_memory_slave_core import wsbms_pkg::*; #(
   parameter int MEM_BYTES = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   wsbms_req_if.sink                  req_ch,
   wsbms_rsp_if.source                rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_wr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequence the clear pass and each access
   wsbms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold registers, counter, store and response
   wsbms_datapath #(
      .MEM_BYTES (MEM_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_operation  (req_ch.operation),
      .req_address    (req_ch.address),
      .req_size_code  (req_ch.size_code),
      .req_write_data (req_ch.write_data),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_status     (rsp_ch.status),
      .rsp_read_data  (rsp_ch.read_data)
   );

endmodule
